[hdl/gpls_pkg.sv]
// Constants and types for the glyph pair ligature substitution unit.
package gpls_pkg;

  localparam int TABLE_ENTRIES    = 64;
  localparam int GLYPH_BITS       = 16;
  localparam int ENTRY_INDEX_BITS = 6;
  localparam int TABLE_IDX_BITS   = $clog2(TABLE_ENTRIES);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_GLYPH = 1'b1;

  typedef logic [GLYPH_BITS-1:0] glyph_t;

  // One buffered output word; lig selects the ligature read data for the glyph.
  typedef struct packed {
    glyph_t glyph;
    logic   lig;
    glyph_t first;
    glyph_t second;
    logic   last;
  } res_word_t;

endpackage

[hdl/glyph_pair_ligature_substitution_unit.sv]
// Glyph pair ligature substitution: pair table, pair compare and output buffer.
// An accepted word is registered in the input register, then in the result buffer; a held glyph goes out with the next.
// Throughput: one item per cycle while in_stall is low; a two-word item holds the result buffer until its
//   second word is taken, so the next item that yields a word waits for that, and longer while out_stall is high.
// Reset clears the entry valid bits, the held glyph and all pipeline valids at once;
//   table payload is undefined until written and needs no clearing pass.
module glyph_pair_ligature_substitution_unit
  import gpls_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [ENTRY_INDEX_BITS-1:0] entry_index,
  input  logic [GLYPH_BITS-1:0]       entry_first,
  input  logic [GLYPH_BITS-1:0]       entry_second,
  input  logic [GLYPH_BITS-1:0]       entry_ligature,
  input  logic                        entry_enable,
  input  logic [GLYPH_BITS-1:0]       glyph_in,
  input  logic                        sequence_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [GLYPH_BITS-1:0]       glyph_out,
  output logic                        is_ligature,
  output logic [GLYPH_BITS-1:0]       part_first,
  output logic [GLYPH_BITS-1:0]       part_second,
  output logic                        last_of_sequence
);

  // input register
  logic                        s0_valid;
  logic                        s0_command;
  logic [ENTRY_INDEX_BITS-1:0] s0_index;
  glyph_t                      s0_first;
  glyph_t                      s0_second;
  glyph_t                      s0_ligature;
  logic                        s0_enable;
  glyph_t                      s0_glyph;
  logic                        s0_end;

  // pair table: compared in parallel, ligature glyphs in a memory
  glyph_t                   pair_first  [TABLE_ENTRIES];
  glyph_t                   pair_second [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] pair_valid;
  glyph_t                   lig_mem     [TABLE_ENTRIES];
  glyph_t                   lig_rd;

  glyph_t held_glyph;
  logic   held_valid;

  // result buffer, up to two words
  res_word_t  r0;
  res_word_t  r1;
  logic [1:0] res_cnt;
  logic       res_two;

  logic                      in_acc;
  logic                      out_acc;
  logic                      is_glyph;
  logic                      is_load;
  logic                      wr_en;
  logic [TABLE_IDX_BITS-1:0] wr_idx;
  logic [TABLE_ENTRIES-1:0]  match;
  logic                      hit;
  logic [TABLE_IDX_BITS-1:0] hit_idx;
  logic                      lig_take;
  logic [1:0]                new_cnt;
  res_word_t                 w0;
  res_word_t                 w1;
  logic                      res_free;
  logic                      s0_adv;
  logic                      res_load;
  logic                      sel1;
  logic [1:0]                res_cnt_next;
  logic                      s0_valid_next;
  glyph_t                    held_glyph_next;
  logic                      held_valid_next;

  assign is_glyph = s0_command == CMD_GLYPH;
  assign is_load  = s0_valid && (s0_command == CMD_LOAD);
  assign wr_idx   = s0_index[TABLE_IDX_BITS-1:0];
  assign wr_en    = is_load &&
                    ({1'b0, s0_index} < (ENTRY_INDEX_BITS+1)'(TABLE_ENTRIES));

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = pair_valid[i] && (pair_first[i] == held_glyph) &&
                 (pair_second[i] == s0_glyph);
    end
  end

  // lowest matching index wins
  always_comb begin
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = TABLE_IDX_BITS'(i);
      end
    end
  end

  assign hit      = |match;
  assign lig_take = is_glyph && held_valid && hit;

  always_comb begin
    new_cnt         = 2'd0;
    w0              = '0;
    w1              = '0;
    held_glyph_next = held_glyph;
    held_valid_next = held_valid;
    if (is_glyph) begin
      if (!held_valid) begin
        if (s0_end) begin
          new_cnt  = 2'd1;
          w0.glyph = s0_glyph;
          w0.last  = 1'b1;
        end else begin
          held_glyph_next = s0_glyph;
          held_valid_next = 1'b1;
        end
      end else if (hit) begin
        new_cnt         = 2'd1;
        w0.lig          = 1'b1;
        w0.first        = held_glyph;
        w0.second       = s0_glyph;
        w0.last         = s0_end;
        held_glyph_next = '0;
        held_valid_next = 1'b0;
      end else begin
        w0.glyph = held_glyph;
        if (s0_end) begin
          new_cnt         = 2'd2;
          w1.glyph        = s0_glyph;
          w1.last         = 1'b1;
          held_glyph_next = '0;
          held_valid_next = 1'b0;
        end else begin
          new_cnt         = 2'd1;
          held_glyph_next = s0_glyph;
        end
      end
    end
  end

  assign out_valid = res_cnt != 2'd0;
  assign out_acc   = out_valid && !out_stall;
  assign res_free  = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && !out_stall);
  assign s0_adv    = s0_valid && ((new_cnt == 2'd0) || res_free);
  assign res_load  = s0_adv && (new_cnt != 2'd0);
  assign in_stall  = s0_valid && !s0_adv;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    res_cnt_next = res_cnt;
    if (res_load) begin
      res_cnt_next = new_cnt;
    end else if (out_acc) begin
      res_cnt_next = res_cnt - 2'd1;
    end
  end

  always_comb begin
    s0_valid_next = s0_valid;
    if (in_acc) begin
      s0_valid_next = 1'b1;
    end else if (s0_adv) begin
      s0_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      res_cnt    <= 2'd0;
      res_two    <= 1'b0;
      held_valid <= 1'b0;
      held_glyph <= '0;
      pair_valid <= '0;
    end else begin
      s0_valid <= s0_valid_next;
      res_cnt  <= res_cnt_next;
      if (res_load) begin
        res_two <= new_cnt == 2'd2;
      end
      if (s0_adv) begin
        held_valid <= held_valid_next;
        held_glyph <= held_glyph_next;
      end
      if (wr_en) begin
        pair_valid[wr_idx] <= s0_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_command  <= command;
      s0_index    <= entry_index;
      s0_first    <= entry_first;
      s0_second   <= entry_second;
      s0_ligature <= entry_ligature;
      s0_enable   <= entry_enable;
      s0_glyph    <= glyph_in;
      s0_end      <= sequence_end;
    end
    if (wr_en) begin
      pair_first[wr_idx]  <= s0_first;
      pair_second[wr_idx] <= s0_second;
    end
    if (res_load) begin
      r0 <= w0;
      r1 <= w1;
    end
  end

  // ligature memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lig_mem[wr_idx] <= s0_ligature;
    end
    if (res_load && lig_take) begin
      lig_rd <= lig_mem[hit_idx];
    end
  end

  // second word of a two-word item goes out once the first has been taken
  assign sel1             = res_two && (res_cnt == 2'd1);
  assign glyph_out        = sel1 ? r1.glyph : (r0.lig ? lig_rd : r0.glyph);
  assign is_ligature      = !sel1 && r0.lig;
  assign part_first       = sel1 ? '0 : r0.first;
  assign part_second      = sel1 ? '0 : r0.second;
  assign last_of_sequence = sel1 ? r1.last : r0.last;

`ifndef SYNTHESIS
  a_two_drain: assert property (@(posedge clk) disable iff (rst)
    (res_cnt == 2'd2) && !out_stall |=> res_cnt == 2'd1)
    else $error("two-word buffer did not drain by one");

  a_hit_clears_held: assert property (@(posedge clk) disable iff (rst)
    s0_adv && lig_take |=> !held_valid)
    else $error("held glyph survived a ligature match");

  a_plain_parts_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_ligature |-> (part_first == '0) && (part_second == '0))
    else $error("pair fields set on a plain glyph");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s0_valid && (res_cnt != 2'd0))
    else $error("input stalled with nothing pending");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    res_cnt == 2'd2 |-> res_two)
    else $error("two words buffered without two-word item");
`endif

endmodule

[verif/tb_glyph_pair_ligature_substitution_unit.sv]
// Self-checking testbench for the glyph pair ligature substitution unit.
`timescale 1ns / 100ps

module tb_glyph_pair_ligature_substitution_unit;
  import gpls_pkg::*;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic                        command;
  logic [ENTRY_INDEX_BITS-1:0] entry_index;
  glyph_t                      entry_first;
  glyph_t                      entry_second;
  glyph_t                      entry_ligature;
  logic                        entry_enable;
  glyph_t                      glyph_in;
  logic                        sequence_end;
  logic                        out_valid;
  logic                        out_stall;
  glyph_t                      glyph_out;
  logic                        is_ligature;
  glyph_t                      part_first;
  glyph_t                      part_second;
  logic                        last_of_sequence;

  // Shadow of the pair table and held glyph; queues the words each input word yields.
  class ligature_shadow;
    glyph_t    first_tbl[TABLE_ENTRIES];
    glyph_t    second_tbl[TABLE_ENTRIES];
    glyph_t    lig_tbl[TABLE_ENTRIES];
    bit        live[TABLE_ENTRIES];
    glyph_t    held;
    bit        held_ok;
    res_word_t words_due[$];
    int        mismatch_count;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        first_tbl[i]  = '0;
        second_tbl[i] = '0;
        lig_tbl[i]    = '0;
        live[i]       = 1'b0;
      end
      held           = '0;
      held_ok        = 1'b0;
      mismatch_count = 0;
    endfunction

    function void push(glyph_t g, logic lig, glyph_t a, glyph_t b, logic last);
      res_word_t w;
      w.glyph  = g;
      w.lig    = lig;
      w.first  = a;
      w.second = b;
      w.last   = last;
      words_due.insert(words_due.size(), w);
    endfunction

    function void apply_word(logic cmd, logic [ENTRY_INDEX_BITS-1:0] idx, glyph_t f,
                             glyph_t s, glyph_t l, logic en, glyph_t g, logic fin);
      int hit;
      hit = -1;
      if (cmd == CMD_LOAD) begin
        first_tbl[idx]  = f;
        second_tbl[idx] = s;
        lig_tbl[idx]    = l;
        live[idx]       = en;
        return;
      end
      if (!held_ok) begin
        if (fin) push(g, 1'b0, '0, '0, 1'b1);
        else begin
          held    = g;
          held_ok = 1'b1;
        end
        return;
      end
      // lowest matching index wins
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (hit < 0 && live[i] && first_tbl[i] == held && second_tbl[i] == g) hit = i;
      if (hit >= 0) begin
        push(lig_tbl[hit], 1'b1, held, g, fin);
        held_ok = 1'b0;
        held    = '0;
        return;
      end
      push(held, 1'b0, '0, '0, 1'b0);
      if (fin) begin
        push(g, 1'b0, '0, '0, 1'b1);
        held_ok = 1'b0;
        held    = '0;
      end else begin
        held = g;
      end
    endfunction

    function void note_fail(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_word(res_word_t got);
      res_word_t want;
      if (words_due.size() == 0) begin
        note_fail($sformatf("unexpected word glyph=%h lig=%b first=%h second=%h last=%b",
                            got.glyph, got.lig, got.first, got.second, got.last));
        return;
      end
      want = words_due.pop_front();
      if (got.glyph !== want.glyph || got.lig !== want.lig || got.first !== want.first ||
          got.second !== want.second || got.last !== want.last)
        note_fail($sformatf({"exp glyph=%h lig=%b first=%h second=%h last=%b, ",
                             "got glyph=%h lig=%b first=%h second=%h last=%b"},
                            want.glyph, want.lig, want.first, want.second, want.last,
                            got.glyph, got.lig, got.first, got.second, got.last));
    endfunction
  endclass

  ligature_shadow shadow;
  bit             quiet;
  int             items_sent;
  glyph_t         alphabet[12];

  glyph_pair_ligature_substitution_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .entry_index      (entry_index),
    .entry_first      (entry_first),
    .entry_second     (entry_second),
    .entry_ligature   (entry_ligature),
    .entry_enable     (entry_enable),
    .glyph_in         (glyph_in),
    .sequence_end     (sequence_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .glyph_out        (glyph_out),
    .is_ligature      (is_ligature),
    .part_first       (part_first),
    .part_second      (part_second),
    .last_of_sequence (last_of_sequence)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // input acceptance is applied before the output check on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        shadow.apply_word(command, entry_index, entry_first, entry_second, entry_ligature,
                          entry_enable, glyph_in, sequence_end);
      if (out_valid && !out_stall)
        shadow.check_word(res_word_t'({glyph_out, is_ligature, part_first, part_second,
                                       last_of_sequence}));
    end
  end

  // output backpressure in random bursts, none while quiet
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          out_stall = 1'b1;
          @(negedge clk);
        end
      end
      out_stall = 1'b0;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic cmd, input logic [ENTRY_INDEX_BITS-1:0] idx,
                           input glyph_t f, input glyph_t s, input glyph_t l,
                           input logic en, input glyph_t g, input logic fin);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap      = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    command        = cmd;
    entry_index    = idx;
    entry_first    = f;
    entry_second   = s;
    entry_ligature = l;
    entry_enable   = en;
    glyph_in       = g;
    sequence_end   = fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // unused fields of each command carry random noise
  task automatic load_entry(input int idx, input glyph_t f, input glyph_t s, input glyph_t l,
                            input logic en);
    send_word(CMD_LOAD, ENTRY_INDEX_BITS'(idx), f, s, l, en, glyph_t'($urandom),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_glyph(input glyph_t g, input logic fin);
    send_word(CMD_GLYPH, ENTRY_INDEX_BITS'($urandom_range(0, TABLE_ENTRIES - 1)),
              glyph_t'($urandom), glyph_t'($urandom), glyph_t'($urandom),
              1'($urandom_range(0, 1)), g, fin);
  endtask

  function automatic glyph_t pick_glyph();
    if ($urandom_range(0, 9) < 7) return alphabet[$urandom_range(0, 11)];
    return glyph_t'($urandom);
  endfunction

  task automatic random_load();
    int     idx;
    int     src;
    glyph_t f;
    glyph_t s;
    idx = $urandom_range(0, TABLE_ENTRIES - 1);
    src = $urandom_range(0, TABLE_ENTRIES - 1);
    // sometimes duplicate an existing pair so index priority matters
    if ($urandom_range(0, 3) == 0) begin
      f = shadow.first_tbl[src];
      s = shadow.second_tbl[src];
    end else begin
      f = pick_glyph();
      s = pick_glyph();
    end
    load_entry(idx, f, s, glyph_t'($urandom), $urandom_range(0, 4) != 0);
  endtask

  task automatic run_sequence();
    int len;
    int i;
    int k;
    bit close;
    len   = $urandom_range(1, 10);
    close = $urandom_range(0, 9) != 0;
    i     = 0;
    while (i < len) begin
      if ($urandom_range(0, 11) == 0) random_load();
      k = $urandom_range(0, TABLE_ENTRIES - 1);
      if (i + 1 < len && shadow.live[k] && $urandom_range(0, 1)) begin
        send_glyph(shadow.first_tbl[k], 1'b0);
        send_glyph(shadow.second_tbl[k], close && (i + 2 == len));
        i += 2;
      end else begin
        send_glyph(pick_glyph(), close && (i + 1 == len));
        i++;
      end
    end
  endtask

  initial begin
    shadow         = new();
    quiet          = 1'b0;
    items_sent     = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = CMD_GLYPH;
    entry_index    = '0;
    entry_first    = '0;
    entry_second   = '0;
    entry_ligature = '0;
    entry_enable   = 1'b0;
    glyph_in       = '0;
    sequence_end   = 1'b0;
    alphabet[0] = 16'h0000;
    alphabet[1] = 16'hFFFF;
    alphabet[2] = 16'h0001;
    alphabet[3] = 16'h8000;
    alphabet[4] = 16'h0041;
    alphabet[5] = 16'h0042;
    for (int i = 6; i < 12; i++) alphabet[i] = glyph_t'($urandom);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table: lone glyph, then a pair with no match
    send_glyph(16'h1234, 1'b1);
    send_glyph(16'h0000, 1'b0);
    send_glyph(16'hFFFF, 1'b1);
    // same pair at both ends of the table, extreme glyphs in a third entry
    load_entry(0, 16'h0041, 16'h0042, 16'hE000, 1'b1);
    load_entry(TABLE_ENTRIES - 1, 16'h0041, 16'h0042, 16'hE03F, 1'b1);
    load_entry(5, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    send_glyph(16'h0041, 1'b0);
    send_glyph(16'h0042, 1'b1);
    // clear entry 0 while a glyph is held; the higher entry must take over
    send_glyph(16'h0041, 1'b0);
    load_entry(0, 16'h0041, 16'h0042, 16'h1111, 1'b0);
    send_glyph(16'h0042, 1'b0);
    send_glyph(16'hFFFF, 1'b0);
    send_glyph(16'h0000, 1'b0);
    send_glyph(16'h0041, 1'b0);
    send_glyph(16'h0041, 1'b0);
    send_glyph(16'h0042, 1'b1);
    // greedy scan: first two glyphs pair up, the third goes out alone
    load_entry(1, 16'h0041, 16'h0041, 16'h0100, 1'b1);
    send_glyph(16'h0041, 1'b0);
    send_glyph(16'h0041, 1'b0);
    send_glyph(16'h0042, 1'b1);

    repeat (24) random_load();
    while (items_sent < 1000) begin
      if (items_sent > 880) quiet = 1'b1;
      run_sequence();
    end
    in_valid = 1'b0;

    while (shadow.words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (shadow.mismatch_count == 0 && shadow.words_due.size() == 0) begin
      $display("tb_glyph_pair_ligature_substitution_unit: PASS");
    end else begin
      $display("tb_glyph_pair_ligature_substitution_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_glyph_pair_ligature_substitution_unit: FAIL");
    $finish;
  end

endmodule

[glyph_pair_ligature_substitution_unit.f]
hdl/gpls_pkg.sv
hdl/glyph_pair_ligature_substitution_unit.sv
verif/tb_glyph_pair_ligature_substitution_unit.sv
